### src/deq_pkg.sv
package deq_pkg;

    localparam int DEPTH    = 16;
    localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int WORD_W   = 32;
    localparam int OPCODE_W = 3;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_PUSH_REAR  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_POP_REAR   = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_PEEK       = 3'd4;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;
        logic exec;
        logic read;
        logic load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage

### src/deq_if.sv
interface deq_in_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [WORD_W-1:0]   value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface deq_out_if;
    import deq_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [WORD_W-1:0]   front_value;
    logic                       is_empty;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, output front_value, output is_empty, output status,
                    input ready);
    modport sink   (input valid, input front_value, input is_empty, input status,
                    output ready);
endinterface

### src/deq_ram.sv
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### src/deq_ctrl.sv
module deq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  deq_pkg::t_sts i_sts,
    output deq_pkg::t_cmd o_cmd
);
    import deq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_READ,
        S_LOAD
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: r_state <= S_READ;
                S_READ: r_state <= S_LOAD;
                S_LOAD: begin
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.read   = (r_state == S_READ);
    assign o_cmd.load   = (r_state == S_LOAD) && i_sts.out_free;

`ifndef NO_ASSERTIONS
    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == S_EXEC) && !o_in_ready)
        else $error("accepted beat did not start execution");

    a_exec_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_cmd.read ##1 (r_state == S_LOAD))
        else $error("store read did not follow execution");
`endif
endmodule

### src/deq_dp.sv
module deq_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  deq_pkg::t_cmd                       i_cmd,
    output deq_pkg::t_sts                       o_sts,
    input  logic [deq_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic signed [deq_pkg::WORD_W-1:0]   i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [deq_pkg::WORD_W-1:0]   o_front_value,
    output logic                                o_is_empty,
    output logic [deq_pkg::STATUS_W-1:0]        o_status
);
    import deq_pkg::*;

    logic [OPCODE_W-1:0] r_op;
    logic [WORD_W-1:0]   r_value;
    logic [ADDR_W-1:0]   r_front, n_front;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [STATUS_W-1:0] r_status, n_status;

    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_front;
    logic                r_out_empty;
    logic [STATUS_W-1:0] r_out_status;

    logic                w_empty;
    logic                w_full;
    logic [ADDR_W-1:0]   w_front_dec;
    logic [ADDR_W-1:0]   w_front_inc;
    logic [ADDR_W:0]     w_rear_sum;
    logic [ADDR_W-1:0]   w_rear;
    logic                w_we;
    logic [ADDR_W-1:0]   w_waddr;
    logic [WORD_W-1:0]   w_rdata;

    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_front_dec = (r_front == '0) ? ADDR_W'(DEPTH - 1) : r_front - ADDR_W'(1);
    assign w_front_inc = (r_front == ADDR_W'(DEPTH - 1)) ? '0 : r_front + ADDR_W'(1);
    // rear slot is front + occupancy, wrapped once (occupancy < DEPTH on a push)
    assign w_rear_sum  = {1'b0, r_front} + (ADDR_W + 1)'(r_count);
    assign w_rear      = (w_rear_sum >= (ADDR_W + 1)'(DEPTH))
                       ? ADDR_W'(w_rear_sum - (ADDR_W + 1)'(DEPTH))
                       : ADDR_W'(w_rear_sum);

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_DONE;
        w_we     = 1'b0;
        w_waddr  = w_rear;
        unique case (r_op)
            OP_PUSH_FRONT: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_front = w_front_dec;
                    n_count = r_count + CNT_W'(1);
                    w_we    = 1'b1;
                    w_waddr = w_front_dec;
                end
            end
            OP_PUSH_REAR: begin
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    w_we    = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_front = w_front_inc;
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_POP_REAR: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_PEEK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end
            end
            default: n_status = ST_DONE;
        endcase
    end

    deq_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.exec && w_we),
        .i_waddr (w_waddr),
        .i_wdata (r_value),
        .i_re    (i_cmd.read),
        .i_raddr (r_front),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_opcode;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
        end
        if (i_cmd.load) begin
            r_out_front  <= w_empty ? '0 : w_rdata;
            r_out_empty  <= w_empty;
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_front <= n_front;
                r_count <= n_count;
            end
            if (i_cmd.load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_front_value  = $signed(r_out_front);
    assign o_is_empty     = r_out_empty;
    assign o_status       = r_out_status;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count <= CNT_W'(DEPTH)) && (r_front <= ADDR_W'(DEPTH - 1)))
        else $error("occupancy or front index out of range");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || i_out_ready))
        else $error("result register overwritten while stalled");

    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_FULL)) |-> !r_out_empty)
        else $error("dropped push reported on empty queue");
`endif
endmodule

### src/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit words in a 16-entry ring.
// Input channel i_in carries opcode and value: push front, push rear,
// pop front, pop rear, peek; other opcodes leave the queue unchanged.
// Output channel o_out returns one beat per input beat: the front word
// after the operation (0 when empty), the empty flag and a status
// (done, pop/peek on empty, push dropped because full).
// Both channels use valid/ready; a beat moves when both are high.
// Timing: an accepted beat is executed the next cycle, the new front
// entry is read from the store the cycle after, and the
// result is registered in the load state once o_out can take it. Each
// item passes through the execute, read and load states in turn: the
// store write is followed by its registered read of the front entry.
// The result register holds its beat while o_out.ready is low; the next
// input beat is taken once that result has been loaded.
// Reset (synchronous, active low) empties the queue and drops any
// pending result; store contents are not cleared.
module double_ended_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    deq_in_if.sink       i_in,
    deq_out_if.source    o_out
);
    import deq_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    deq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    deq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_opcode      (i_in.opcode),
        .i_value       (i_in.value),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_front_value (o_out.front_value),
        .o_is_empty    (o_out.is_empty),
        .o_status      (o_out.status)
    );
endmodule

### tb/deq_checker.sv
`timescale 1ns / 100ps

module deq_checker
    import deq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    deq_in_if    i_in_mon,
    deq_out_if   i_out_mon,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_checked,
    output int   o_full_drops,
    output int   o_empty_hits
);

    typedef struct packed {
        logic signed [WORD_W-1:0] front_value;
        logic                     is_empty;
        logic [STATUS_W-1:0]      status;
    } t_deq_report;

    logic signed [WORD_W-1:0] ring [DEPTH];
    int                       head_idx;
    int                       word_count;
    t_deq_report              reports_due [$];
    int                       mismatch_cnt;
    int                       checked_cnt;
    int                       full_cnt;
    int                       empty_cnt;

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_cnt++;
    endtask

    // Advances the mirrored ring by one operation and returns the beat it must produce.
    function automatic t_deq_report apply_op(input logic [OPCODE_W-1:0] op,
                                             input logic signed [WORD_W-1:0] word);
        t_deq_report rep;
        rep.status = ST_DONE;
        case (op)
            OP_PUSH_FRONT: begin
                if (word_count >= DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    head_idx = (head_idx + DEPTH - 1) % DEPTH;
                    ring[head_idx] = word;
                    word_count++;
                end
            end
            OP_PUSH_REAR: begin
                if (word_count >= DEPTH) begin
                    rep.status = ST_FULL;
                end else begin
                    ring[(head_idx + word_count) % DEPTH] = word;
                    word_count++;
                end
            end
            OP_POP_FRONT: begin
                if (word_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    head_idx = (head_idx + 1) % DEPTH;
                    word_count--;
                end
            end
            OP_POP_REAR: begin
                if (word_count == 0) begin
                    rep.status = ST_EMPTY;
                end else begin
                    word_count--;
                end
            end
            OP_PEEK: begin
                if (word_count == 0) begin
                    rep.status = ST_EMPTY;
                end
            end
            default: ;  // unused opcodes leave the queue alone
        endcase
        rep.is_empty    = (word_count == 0);
        rep.front_value = (word_count != 0) ? ring[head_idx] : '0;
        return rep;
    endfunction

    always @(posedge i_clk) begin : watch
        t_deq_report want;
        t_deq_report made;
        if (!i_rst_n) begin
            head_idx   = 0;
            word_count = 0;
            reports_due.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (reports_due.size() == 0) begin
                    report_mismatch($sformatf("result beat with nothing expected (front %0d)",
                                              i_out_mon.front_value));
                end else begin
                    want = reports_due.pop_front();
                    checked_cnt++;
                    if (i_out_mon.front_value !== want.front_value)
                        report_mismatch($sformatf("front_value %0d, expected %0d",
                                                  i_out_mon.front_value, want.front_value));
                    if (i_out_mon.is_empty !== want.is_empty)
                        report_mismatch($sformatf("is_empty %b, expected %b",
                                                  i_out_mon.is_empty, want.is_empty));
                    if (i_out_mon.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  i_out_mon.status, want.status));
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                made = apply_op(i_in_mon.opcode, i_in_mon.value);
                if (made.status == ST_FULL)
                    full_cnt++;
                if (made.status == ST_EMPTY)
                    empty_cnt++;
                reports_due.push_back(made);
            end
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= reports_due.size();
        o_checked    <= checked_cnt;
        o_full_drops <= full_cnt;
        o_empty_hits <= empty_cnt;
    end

endmodule

### tb/tb_double_ended_queue.sv
`timescale 1ns / 100ps

module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int RANDOM_ITEMS = 1825;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [OPCODE_W-1:0]     OP_LAST  = '1;
    localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7fff_ffff;
    localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} t_traffic_mode;

    logic clk;
    logic rst_n;
    bit   idle_on;
    int   cycle_cnt;
    int   mismatches;
    int   pending;
    int   checked;
    int   full_drops;
    int   empty_hits;

    deq_in_if  in_ch ();
    deq_out_if out_ch ();

    double_ended_queue dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    deq_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_full_drops (full_drops),
        .o_empty_hits (empty_hits)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, pending);
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk) begin
        out_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 18);
    end

    // valid stays up across back-to-back beats; only a gap lowers it
    task automatic send(input logic [OPCODE_W-1:0] op, input logic signed [WORD_W-1:0] word);
        while (idle_on && $urandom_range(0, 99) < 18) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= word;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // pending is registered in the checker, so check it only after the next clock edge
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [OPCODE_W-1:0] pick_op(input t_traffic_mode mode);
        int r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL: begin
                if (r < 35)      return OP_PUSH_FRONT;
                else if (r < 70) return OP_PUSH_REAR;
                else if (r < 80) return OP_POP_FRONT;
                else if (r < 90) return OP_POP_REAR;
                else if (r < 96) return OP_PEEK;
            end
            MODE_DRAIN: begin
                if (r < 10)      return OP_PUSH_FRONT;
                else if (r < 20) return OP_PUSH_REAR;
                else if (r < 45) return OP_POP_FRONT;
                else if (r < 70) return OP_POP_REAR;
                else if (r < 95) return OP_PEEK;
            end
            default: begin
                if (r < 22)      return OP_PUSH_FRONT;
                else if (r < 44) return OP_PUSH_REAR;
                else if (r < 66) return OP_POP_FRONT;
                else if (r < 88) return OP_POP_REAR;
                else if (r < 96) return OP_PEEK;
            end
        endcase
        // one of the unused opcodes above peek
        return OP_PEEK + OPCODE_W'($urandom_range(1, OP_LAST - OP_PEEK));
    endfunction

    function automatic logic signed [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return -1;
            3:       return 0;
            4, 5:    return $signed($urandom_range(0, 255)) - 128;
            default: return $urandom;
        endcase
    endfunction

    initial begin : stimulus
        t_traffic_mode mode;
        int            burst_left;
        in_ch.valid  = 1'b0;
        in_ch.opcode = OP_PEEK;
        in_ch.value  = '0;
        rst_n        = 1'b0;
        idle_on      = 1'b1;
        mode         = MODE_MIX;
        burst_left   = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // empty queue corners
        send(OP_PEEK, 0);
        send(OP_POP_FRONT, 32'sh1234_5678);
        send(OP_POP_REAR, 0);
        send(OP_LAST, -1);
        send(OP_PUSH_FRONT, WORD_MAX);
        send(OP_PUSH_REAR, WORD_MIN);
        send(OP_POP_REAR, 0);
        send(OP_POP_FRONT, 0);
        // fill from both ends, then overflow
        for (int i = 0; i < DEPTH; i++)
            send((i % 2) ? OP_PUSH_REAR : OP_PUSH_FRONT,
                 (i == 0) ? -1 : (i == 1) ? 0 : $signed($urandom));
        send(OP_PUSH_FRONT, 1);
        send(OP_PUSH_REAR, 2);
        send(OP_PEEK, 0);
        wait_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (burst_left == 0) begin
                mode       = t_traffic_mode'($urandom_range(0, 2));
                burst_left = $urandom_range(10, 60);
            end
            burst_left--;
            idle_on <= !(n >= 700 && n < 1000);
            if (n > 0 && n % 450 == 0)
                wait_drained();
            send(pick_op(mode), pick_value());
        end
        wait_drained();
        repeat (10) @(posedge clk);

        $display("%0d results checked: %0d pushes dropped on a full queue, %0d pops/peeks on empty",
                 checked, full_drops, empty_hits);
        $display("%0d mismatches over directed corners and mixed fill/drain traffic", mismatches);
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

### files.f
src/deq_pkg.sv
src/deq_if.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue.sv
tb/deq_checker.sv
tb/tb_double_ended_queue.sv
